>>> rtl/url_percent_decoder_defines.svh
// Assertion macros for the url_percent_decoder checker.
// Depends on nothing; expects clk and rst_n in the including scope.
`ifndef URL_PERCENT_DECODER_DEFINES_SVH
`define URL_PERCENT_DECODER_DEFINES_SVH

// Check a property on every clock edge outside reset
`define UPD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included
`define UPD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/upd_pkg.sv
// Package for the percent decoder: character codes, phase codes, result types
// and hex helpers. No dependencies.
`default_nettype none

package upd_pkg;

    // Character codes
    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] SPACE_CHAR = 8'h20;

    // Decode phase codes
    localparam logic [1:0] PHASE_PLAIN = 2'd0;
    localparam logic [1:0] PHASE_PCT   = 2'd1;
    localparam logic [1:0] PHASE_DIGIT = 2'd2;

    // One output word
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } word_t;

    // Up to three words caused by one input byte
    typedef struct packed {
        logic [1:0] cnt;
        word_t      w0;
        word_t      w1;
        word_t      w2;
    } res_t;

    function automatic logic is_hex(input logic [7:0] b);
        logic res;
        res = ((b >= 8'h30) && (b <= 8'h39)) || ((b >= 8'h41) && (b <= 8'h46)) ||
              ((b >= 8'h61) && (b <= 8'h66));
        return res;
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [7:0] v;
        v = 8'h00;
        if ((b >= 8'h30) && (b <= 8'h39))
        begin
            v = b - 8'h30;
        end
        else if ((b >= 8'h41) && (b <= 8'h46))
        begin
            v = b - 8'h37;
        end
        else if ((b >= 8'h61) && (b <= 8'h66))
        begin
            v = b - 8'h57;
        end
        return v[3:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/upd_decode.sv
// Decode step: phase and held digit registers plus the logic that turns one
// byte into zero to three words. Depends on upd_pkg.
`default_nettype none

module upd_decode
    import upd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       advance,   // consume the byte below this cycle
    input  wire logic [7:0] cur_byte,
    input  wire logic       cur_last,
    output res_t            res
);

    logic [1:0] phase_reg, phase_next;
    logic [7:0] held_reg, held_next;

    logic       p_emit;
    word_t      p_word;
    logic [1:0] p_phase;
    logic       cur_hex;

    // Plain-phase handling of the current byte
    always_comb
    begin
        p_emit  = 1'b1;
        p_word  = '{data: cur_byte, last: cur_last};
        p_phase = PHASE_PLAIN;
        if (cur_byte == PCT_CHAR)
        begin
            if (cur_last)
            begin
                p_word = '{data: PCT_CHAR, last: 1'b1};
            end
            else
            begin
                p_emit  = 1'b0;
                p_phase = PHASE_PCT;
            end
        end
        else if (cur_byte == PLUS_CHAR)
        begin
            p_word = '{data: SPACE_CHAR, last: cur_last};
        end
    end

    assign cur_hex = is_hex(cur_byte);

    // Build the words and the next phase
    always_comb
    begin
        res        = '0;
        phase_next = phase_reg;
        held_next  = held_reg;
        case (phase_reg)
            PHASE_PCT:
            begin
                if (cur_hex)
                begin
                    if (cur_last)
                    begin
                        res.w0     = '{data: PCT_CHAR, last: 1'b0};
                        res.w1     = '{data: cur_byte, last: 1'b1};
                        res.cnt    = 2'd2;
                        phase_next = PHASE_PLAIN;
                    end
                    else
                    begin
                        held_next  = cur_byte;
                        phase_next = PHASE_DIGIT;
                    end
                end
                else
                begin
                    // broken sequence: flush the percent, then the byte afresh
                    res.w0     = '{data: PCT_CHAR, last: 1'b0};
                    res.w1     = p_word;
                    res.cnt    = p_emit ? 2'd2 : 2'd1;
                    phase_next = p_phase;
                end
            end
            PHASE_DIGIT:
            begin
                if (cur_hex)
                begin
                    res.w0     = '{data: {hex_val(held_reg), hex_val(cur_byte)},
                                   last: cur_last};
                    res.cnt    = 2'd1;
                    phase_next = PHASE_PLAIN;
                end
                else
                begin
                    res.w0     = '{data: PCT_CHAR, last: 1'b0};
                    res.w1     = '{data: held_reg, last: 1'b0};
                    res.w2     = p_word;
                    res.cnt    = p_emit ? 2'd3 : 2'd2;
                    phase_next = p_phase;
                end
            end
            default:
            begin
                res.w0     = p_word;
                res.cnt    = p_emit ? 2'd1 : 2'd0;
                phase_next = p_phase;
            end
        endcase
    end

    // Update state only when the byte is consumed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_PLAIN;
            held_reg  <= 8'h00;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/upd_outbuf.sv
// Result register: three fixed word slots that drain one word per cycle while m_tready is high.
// Depends on upd_pkg.
`default_nettype none

module upd_outbuf
    import upd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       load,
    input  wire res_t       res,
    output logic            can_load,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tlast
);

    logic [1:0] cnt_reg, cnt_next;
    word_t      s0_reg, s0_next;
    word_t      s1_reg, s1_next;
    word_t      s2_reg, s2_next;
    logic       pop;

    assign pop      = m_tvalid && m_tready;
    assign can_load = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop);

    // Load a fresh set of words or shift toward slot 0
    always_comb
    begin
        cnt_next = cnt_reg;
        s0_next  = s0_reg;
        s1_next  = s1_reg;
        s2_next  = s2_reg;
        if (load)
        begin
            cnt_next = res.cnt;
            s0_next  = res.w0;
            s1_next  = res.w1;
            s2_next  = res.w2;
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - 2'd1;
            s0_next  = s1_reg;
            s1_next  = s2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_reg <= s0_next;
        s1_reg <= s1_next;
        s2_reg <= s2_next;
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = s0_reg.data;
    assign m_tlast  = s0_reg.last;

endmodule

`default_nettype wire

>>> rtl/url_percent_decoder.sv
// Percent decoder for form-urlencoded text: one encoded byte per word in, one
// decoded byte per word out; '%' plus two hex digits becomes one byte, '+'
// becomes a space, broken or cut-off sequences pass through literally. A byte
// passes through the input register, then the result register, on its way to
// the output. Throughput is one byte per cycle while each byte yields at most
// one word and the output is not stalled; a byte that yields two or three words
// (a broken or cut-off sequence) holds the input while the result register drains.
// Depends on upd_pkg, upd_decode and upd_outbuf.
`default_nettype none

module url_percent_decoder
    import upd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tlast,   // in_last
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tlast    // out_last
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       can_load;
    logic       advance;
    res_t       res;

    // Consume the held byte once the result register can take its words
    assign advance  = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Capture the input word
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    upd_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .cur_byte (in_byte_reg),
        .cur_last (in_last_reg),
        .res      (res)
    );

    upd_outbuf u_outbuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .res      (res),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

>>> rtl/upd_checker.sv
// Port-level checker for url_percent_decoder, bound to the top level.
// Depends on url_percent_decoder_defines.svh.
`default_nettype none

`include "url_percent_decoder_defines.svh"

module upd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic [7:0] s_tdata,
    input wire logic       s_tlast,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    // Stalled output word holds
    `UPD_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output word changed while stalled")

    // Empty output side never blocks input
    `UPD_ASSERT(a_ready_when_idle, !m_tvalid |-> s_tready, "input blocked with no output pending")

    // A new output burst stems from an earlier accepted input word
    `UPD_ASSERT(a_out_from_in, $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2), "output appeared without an input word")

    // No output during reset
    `UPD_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !m_tvalid, "output valid during reset")

endmodule

bind url_percent_decoder upd_checker u_upd_checker (.*);

`default_nettype wire
